@@ src/bwcs_pkg.sv @@
// Shared types and constants for the best-window column synthesis block.
// No dependencies; compiled first.
`default_nettype none

package bwcs_pkg;

  // Fixed geometry of the sample store and of one column
  localparam int unsigned MAX_SAMPLE     = 1024;
  localparam int unsigned ROWS           = 2;
  localparam int unsigned VALUE_BITS     = 16;
  localparam int unsigned MAX_WINDOW_DEF = 32;

  localparam int unsigned SA_BITS   = $clog2(MAX_SAMPLE);      // sample address
  localparam int unsigned LEN_BITS  = $clog2(MAX_SAMPLE + 1);  // sample length value
  localparam int unsigned COL_BITS  = ROWS * VALUE_BITS;       // one stored column
  localparam int unsigned WS_BITS   = 6;                       // window_size register
  localparam int unsigned SL_BITS   = 11;                      // sample_length register
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 11;

  // Operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEED   = 2'd1;
  localparam logic [1:0] OP_SYNTH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_LENGTH = 1'd1;

  localparam logic [WS_BITS-1:0] WINDOW_SIZE_RST = 6'd10;

  typedef struct packed {
    logic [1:0]            op;
    logic [9:0]            column_index;
    logic [VALUE_BITS-1:0] value_top;
    logic [VALUE_BITS-1:0] value_bottom;
    logic [9:0]            seed_offset;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] out_top;
    logic [VALUE_BITS-1:0] out_bottom;
    logic [9:0]            match_position;
    logic                  no_match;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

@@ src/bwcs_intf.sv @@
// Valid/ready channel interfaces for input requests, results and config writes.
// Depends on bwcs_pkg for the payload structs.
`default_nettype none

interface bwcs_in_if;
  import bwcs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bwcs_out_if;
  import bwcs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bwcs_cfg_if;
  import bwcs_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/best_window_column_synthesis.sv @@
// Top level of the best-window column synthesis block: sequencer, shared squarer.
// Depends on bwcs_pkg, bwcs_intf (channel interfaces) and bwcs_ram.
//
//  channel | dir | payload                                          | notes
//  in_i    | in  | op, column_index, value_top/bottom, seed_offset  | ready only when idle
//  cfg_i   | in  | index, data                                      | always ready
//  out_o   | out | out_top/bottom, match_position, no_match         | one per synthesize request
//
// Load writes one sample column. Seed copies w columns, one sample read and one window
// write per column. Synthesize scans count = sample_length - w - 1 candidates; each window
// column passes ST_SQ0, ST_SQ1 and ST_ACC: the single squarer, used once per row, then its
// accumulate. No candidate gives a no_match result. Reset clears the sequencer, window head and config registers;
// both RAMs keep their contents. A stalled result holds the sequencer in its last state
// until taken; a new request is accepted while a result waits.
`default_nettype none

module best_window_column_synthesis #(
  parameter int unsigned MAX_WINDOW = bwcs_pkg::MAX_WINDOW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bwcs_in_if.sink       in_i,
  bwcs_cfg_if.sink      cfg_i,
  bwcs_out_if.source    out_o
);

  import bwcs_pkg::*;

  localparam int unsigned WA = $clog2(MAX_WINDOW);        // window slot address
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);    // window size value
  localparam int unsigned DW = 2 * VALUE_BITS + 2 + WA;   // distance accumulator

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_ADDR,
    ST_SQ0,
    ST_SQ1,
    ST_ACC,
    ST_CMP,
    ST_FETCH,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [WS_BITS-1:0]    ws_q;
  logic [SL_BITS-1:0]    sl_q;
  logic [WA-1:0]         head_q;
  logic [WA-1:0]         base_q;
  logic [WA-1:0]         c_q;
  logic [WA-1:0]         slot_q;
  logic                  last_q;
  logic [SA_BITS-1:0]    j_q;
  logic [SA_BITS-1:0]    count_q;
  logic [SA_BITS-1:0]    off_q;
  logic [SA_BITS-1:0]    best_q;
  logic [DW-1:0]         best_dist_q;
  logic [DW-1:0]         acc_q;
  logic                  found_q;
  logic                  nm_q;
  logic [VALUE_BITS-1:0] diff1_q;
  logic [2*VALUE_BITS-1:0] prod_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic in_acc, out_free;
  logic [WW-1:0]        w_eff;
  logic [LEN_BITS-1:0]  l_eff;
  logic [LEN_BITS:0]    lx, wx;
  logic                 no_cand;
  logic [SA_BITS-1:0]   count_new;
  logic [SA_BITS-1:0]   lim, off_new;
  logic [WW:0]          hx, wbx;
  logic [WA-1:0]        base_new;
  logic [WA-1:0]        head_seed;
  logic [WA-1:0]        slot_inc, head_inc;
  logic                 c_last;

  logic                 smp_we, smp_re, win_we, win_re;
  logic [SA_BITS-1:0]   smp_raddr;
  logic [WA-1:0]        win_waddr;
  logic [COL_BITS-1:0]  smp_rdata, win_rdata;

  logic [VALUE_BITS-1:0] s0, s1, r0, r1, diff0, diff1, mul_a;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Effective window size and sample length
  always_comb begin
    if (ws_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(ws_q) > 32'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(ws_q);
    end
    if (32'(sl_q) > 32'(MAX_SAMPLE)) begin
      l_eff = LEN_BITS'(MAX_SAMPLE);
    end else begin
      l_eff = LEN_BITS'(sl_q);
    end
  end

  // Candidate count, seed offset limit, window base slot
  always_comb begin
    lx        = {1'b0, l_eff};
    wx        = (LEN_BITS + 1)'(w_eff);
    no_cand   = lx < (wx + (LEN_BITS + 1)'(2));
    count_new = SA_BITS'(lx - wx - (LEN_BITS + 1)'(1));
    lim       = (lx > wx) ? SA_BITS'(lx - wx) : '0;
    off_new   = (SA_BITS'(in_i.payload.seed_offset) > lim) ? lim
                                                           : SA_BITS'(in_i.payload.seed_offset);
    hx        = (WW + 1)'(head_q);
    wbx       = (WW + 1)'(w_eff);
    base_new  = (hx >= wbx) ? WA'(hx - wbx) : WA'(hx + (WW + 1)'(MAX_WINDOW) - wbx);
    head_seed = (32'(w_eff) == 32'(MAX_WINDOW)) ? '0 : WA'(w_eff);
    slot_inc  = (32'(slot_q) == 32'(MAX_WINDOW - 1)) ? '0 : slot_q + WA'(1);
    head_inc  = (32'(head_q) == 32'(MAX_WINDOW - 1)) ? '0 : head_q + WA'(1);
    c_last    = (WW'(c_q) + WW'(1)) == w_eff;
  end

  // Memory controls
  always_comb begin
    smp_we    = in_acc && (in_i.payload.op == OP_LOAD);
    smp_re    = 1'b0;
    smp_raddr = j_q + SA_BITS'(c_q);
    win_re    = 1'b0;
    win_we    = 1'b0;
    win_waddr = head_q;
    case (state_q)
      ST_SEED_RD: begin
        smp_re    = 1'b1;
        smp_raddr = off_q + SA_BITS'(c_q);
      end
      ST_SEED_WR: begin
        win_we    = 1'b1;
        win_waddr = c_q;
      end
      ST_ADDR: begin
        smp_re = 1'b1;
        win_re = 1'b1;
      end
      ST_ACC: begin
        smp_re = !last_q;
        win_re = !last_q;
      end
      ST_FETCH: begin
        smp_re    = 1'b1;
        smp_raddr = best_q + SA_BITS'(w_eff);
      end
      ST_DONE: begin
        win_we = out_free && !nm_q;
      end
      default: begin
      end
    endcase
  end

  bwcs_ram #(
    .WIDTH (COL_BITS),
    .DEPTH (MAX_SAMPLE)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (SA_BITS'(in_i.payload.column_index)),
    .wdata_i ({in_i.payload.value_bottom, in_i.payload.value_top}),
    .re_i    (smp_re),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  bwcs_ram #(
    .WIDTH (COL_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (smp_rdata),
    .re_i    (win_re),
    .raddr_i (slot_q),
    .rdata_o (win_rdata)
  );

  // Row differences and the shared squarer input
  always_comb begin
    s0    = smp_rdata[VALUE_BITS-1:0];
    s1    = smp_rdata[COL_BITS-1:VALUE_BITS];
    r0    = win_rdata[VALUE_BITS-1:0];
    r1    = win_rdata[COL_BITS-1:VALUE_BITS];
    diff0 = (s0 > r0) ? s0 - r0 : r0 - s0;
    diff1 = (s1 > r1) ? s1 - r1 : r1 - s1;
    mul_a = (state_q == ST_SQ0) ? diff0 : diff1_q;
  end

  // Sequencer, config registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= WINDOW_SIZE_RST;
      sl_q        <= '0;
      head_q      <= '0;
      base_q      <= '0;
      c_q         <= '0;
      slot_q      <= '0;
      last_q      <= 1'b0;
      j_q         <= '0;
      count_q     <= '0;
      off_q       <= '0;
      best_q      <= '0;
      best_dist_q <= '0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      nm_q        <= 1'b0;
      diff1_q     <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.payload.index)
          CFG_WINDOW_SIZE:   ws_q <= cfg_i.payload.data[WS_BITS-1:0];
          CFG_SAMPLE_LENGTH: sl_q <= cfg_i.payload.data[SL_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.payload.op)
              OP_SEED: begin
                off_q   <= off_new;
                c_q     <= '0;
                state_q <= ST_SEED_RD;
              end
              OP_SYNTH: begin
                if (no_cand) begin
                  nm_q    <= 1'b1;
                  state_q <= ST_DONE;
                end else begin
                  nm_q    <= 1'b0;
                  count_q <= count_new;
                  base_q  <= base_new;
                  slot_q  <= base_new;
                  j_q     <= '0;
                  c_q     <= '0;
                  acc_q   <= '0;
                  found_q <= 1'b0;
                  state_q <= ST_ADDR;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // seed copy: read one sample column, write it to the window
        ST_SEED_RD: begin
          state_q <= ST_SEED_WR;
        end
        ST_SEED_WR: begin
          if (c_last) begin
            head_q  <= head_seed;
            state_q <= ST_IDLE;
          end else begin
            c_q     <= c_q + WA'(1);
            state_q <= ST_SEED_RD;
          end
        end

        // scan: per column square top row, then bottom row, then accumulate
        ST_ADDR: begin
          state_q <= ST_SQ0;
        end
        ST_SQ0: begin
          diff1_q <= diff1;
          prod_q  <= mul_a * mul_a;
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          acc_q   <= acc_q + DW'(prod_q);
          prod_q  <= mul_a * mul_a;
          last_q  <= c_last;
          c_q     <= c_q + WA'(1);
          slot_q  <= slot_inc;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q   <= acc_q + (DW'(prod_q) << 1);
          state_q <= last_q ? ST_CMP : ST_SQ0;
        end
        ST_CMP: begin
          // strict compare keeps the first minimum
          if (!found_q || (acc_q < best_dist_q)) begin
            best_q      <= j_q;
            best_dist_q <= acc_q;
          end
          found_q <= 1'b1;
          if ((j_q + SA_BITS'(1)) == count_q) begin
            state_q <= ST_FETCH;
          end else begin
            j_q     <= j_q + SA_BITS'(1);
            c_q     <= '0;
            slot_q  <= base_q;
            acc_q   <= '0;
            state_q <= ST_ADDR;
          end
        end

        ST_FETCH: begin
          state_q <= ST_DONE;
        end

        // emit result and, on a match, append the winning column once the output slot frees
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (nm_q) begin
              out_q <= '{out_top: '0, out_bottom: '0, match_position: '0, no_match: 1'b1};
            end else begin
              out_q.out_top        <= s0;
              out_q.out_bottom     <= s1;
              out_q.match_position <= 10'(best_q);
              out_q.no_match       <= 1'b0;
              head_q               <= head_inc;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

@@ src/bwcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none

module bwcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
